>>> design/dds_tuning_word_converter_unit_macros.svh
// assertion macros used by the tuning word converter checker
`ifndef DDS_TUNING_WORD_CONVERTER_UNIT_MACROS_SVH
`define DDS_TUNING_WORD_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DTWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dtwc_pkg.sv
// shared types and constants of the tuning word converter
package dtwc_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned MilliW    = 10;
  localparam int unsigned OpW       = 2;
  localparam int unsigned DivNumW   = 64;
  localparam int unsigned DivCntW   = 7;
  localparam int unsigned FracNumW  = 44;
  localparam int unsigned MilliNumW = 45;
  localparam int unsigned AddrW     = 3;

  // divide by one thousand: 22-bit digits and a reciprocal multiply
  localparam int unsigned DigitW     = 22;
  localparam int unsigned RecipShift = 42;
  localparam int unsigned RecipProdW = 65;

  localparam logic [WordW-1:0] WordDefault   = 32'h3555_5555;
  localparam logic [WordW-1:0] WordMax       = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] SysclkDefault = 32'd983_040_000;

  localparam logic [9:0]  MilliScale = 10'd1000;
  localparam logic [8:0]  MilliHalf  = 9'd500;
  localparam logic [10:0] MsScale    = 11'd2000;

  // ceil(2^42 / 1000), exact for any 32-bit dividend
  localparam logic [32:0] RecipMilli  = 33'd4398046512;
  localparam logic [1:0]  MilliDigits = 2'd2;

  localparam logic [DivCntW-1:0] StepsWhole = 7'd64;
  localparam logic [DivCntW-1:0] StepsFrac  = 7'd44;

  // register index bit of paddr
  localparam logic RegIdxSysclk = 1'b0;

  typedef enum logic [OpW-1:0] {
    OP_SET     = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTORE = 2'd2,
    OP_SPARE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_DECODE,
    CMD_PREP,
    CMD_DIV2,
    CMD_ROUND,
    CMD_DIV3,
    CMD_SUM,
    CMD_MUL,
    CMD_FRAC,
    CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    logic op_set;
    logic clk_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/dtwc_div.sv
// restoring divider, one quotient bit per cycle
module dtwc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dtwc_pkg::DivNumW-1:0]  num_i,
  input  logic [dtwc_pkg::WordW-1:0]    den_i,
  input  logic [dtwc_pkg::DivCntW-1:0]  steps_i,
  output logic [dtwc_pkg::DivNumW-1:0]  quot_o,
  output logic [dtwc_pkg::WordW-1:0]    rem_o,
  output logic                          done_o
);
  import dtwc_pkg::*;

  logic [DivNumW-1:0] num_q, quot_q;
  logic [WordW-1:0]   rem_q, den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;

  logic [WordW:0] trial, diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, num_q[DivNumW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[DivNumW-2:0], 1'b0};
      quot_q <= {quot_q[DivNumW-2:0], ge};
      rem_q  <= ge ? diff[WordW-1:0] : trial[WordW-1:0];
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

>>> design/dtwc_datapath.sv
// datapath: word store, divider, multipliers and result register
module dtwc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        capture_i,
  input  dtwc_pkg::op_e               op_i,
  input  logic [dtwc_pkg::WordW-1:0]  whole_i,
  input  logic [dtwc_pkg::MilliW-1:0] milli_i,
  input  logic                        cfg_we_i,
  input  logic [dtwc_pkg::WordW-1:0]  cfg_wdata_i,
  input  dtwc_pkg::cmd_e              cmd_i,
  input  logic                        m_ready_i,
  output dtwc_pkg::dp_status_t        status_o,
  output logic [dtwc_pkg::WordW-1:0]  sysclk_o,
  output logic                        m_valid_o,
  output logic [dtwc_pkg::WordW-1:0]  out_word_o,
  output logic [dtwc_pkg::WordW-1:0]  out_whole_o,
  output logic [dtwc_pkg::MilliW-1:0] out_milli_o,
  output logic                        out_sat_o
);
  import dtwc_pkg::*;

  logic [WordW-1:0]     sysclk_q, word_q, whole_q;
  logic [MilliW-1:0]    milli_q;
  op_e                  op_q;
  logic                 sat_q;
  logic [DivNumW-1:0]   qwhole_q;
  logic [MilliNumW-1:0] num_q;
  logic [2*WordW-1:0]   prod_q;
  logic [10:0]          scaled_hi_q;
  logic                 out_valid_q;
  logic [WordW-1:0]     out_word_q, out_whole_q;
  logic [MilliW-1:0]    out_milli_q;
  logic                 out_sat_q;
  logic [2*DigitW-1:0]  kd_num_q, kd_quot_q;
  logic [MilliW-1:0]    kd_rem_q;
  logic [DigitW-1:0]    kd_digit_q;
  logic [1:0]           kd_cnt_q;
  logic                 kd_phase_q, kd_busy_q, kd_done_q;

  logic                 clk_zero;
  logic                 div_start, div_done;
  logic [DivNumW-1:0]   div_num, div_quot;
  logic [WordW-1:0]     div_den, div_rem;
  logic [DivCntW-1:0]   div_steps;
  logic [41:0]          rem_scaled;
  logic [MilliNumW-1:0] frac_num;
  logic [DivNumW-1:0]   word_sum;
  logic                 sum_sat;
  logic [42:0]          low_scaled;
  logic [11:0]          ms_inc;
  logic                 kd_start;
  logic [WordW-1:0]     kd_trial, kd_back;
  logic [RecipProdW-1:0] kd_prod;

  assign clk_zero = (sysclk_q == '0);
  assign kd_start = (cmd_i == CMD_DIV3);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = sysclk_q;
    div_steps = StepsWhole;
    case (cmd_i)
      CMD_DECODE: begin
        div_start = (op_q == OP_SET) && !clk_zero;
        div_num   = {whole_q, {WordW{1'b0}}};
      end
      CMD_DIV2: begin
        div_start = 1'b1;
        div_num   = {num_q[FracNumW-1:0], {(DivNumW-FracNumW){1'b0}}};
        div_steps = StepsFrac;
      end
      default: ;
    endcase
  end

  dtwc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quot_o  (div_quot),
    .rem_o   (div_rem),
    .done_o  (div_done)
  );

  // milli * 2^32 + rem * 1000 + half the clock, ready for the rounding divide
  always_comb begin
    rem_scaled = 42'(div_rem) * 42'(MilliScale);
    frac_num   = MilliNumW'({milli_q, {WordW{1'b0}}}) + MilliNumW'(rem_scaled)
               + MilliNumW'(sysclk_q[WordW-1:1]);
    word_sum   = qwhole_q + DivNumW'(kd_quot_q);
    sum_sat    = |word_sum[DivNumW-1:WordW];
    low_scaled = 43'(prod_q[WordW-1:0]) * 43'(MsScale);
    ms_inc     = 12'(scaled_hi_q) + 12'd1;
  end

  // divide by one thousand a 22-bit digit at a time: reciprocal multiply, then the remainder
  always_comb begin
    kd_trial = {kd_rem_q, kd_num_q[2*DigitW-1:DigitW]};
    kd_prod  = RecipProdW'(kd_trial) * RecipProdW'(RecipMilli);
    kd_back  = kd_trial - WordW'(kd_digit_q) * WordW'(MilliScale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sysclk_q    <= SysclkDefault;
      word_q      <= WordDefault;
      out_valid_q <= 1'b0;
      kd_busy_q   <= 1'b0;
      kd_done_q   <= 1'b0;
      kd_phase_q  <= 1'b0;
      kd_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        sysclk_q <= cfg_wdata_i;
      end
      case (cmd_i)
        CMD_DECODE: begin
          if (op_q == OP_RESTORE) begin
            word_q <= WordDefault;
          end else if (op_q == OP_SET && clk_zero) begin
            word_q <= WordMax;
          end
        end
        CMD_SUM: word_q <= sum_sat ? WordMax : word_sum[WordW-1:0];
        default: ;
      endcase
      if (cmd_i == CMD_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // per digit: quotient digit first, remainder after
      kd_done_q <= 1'b0;
      if (kd_start) begin
        kd_busy_q  <= 1'b1;
        kd_phase_q <= 1'b0;
        kd_cnt_q   <= MilliDigits;
      end else if (kd_busy_q) begin
        kd_phase_q <= !kd_phase_q;
        if (kd_phase_q) begin
          kd_cnt_q <= kd_cnt_q - 1'b1;
          if (kd_cnt_q == 2'd1) begin
            kd_busy_q <= 1'b0;
            kd_done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      op_q    <= op_i;
      whole_q <= whole_i;
      milli_q <= milli_i;
      sat_q   <= 1'b0;
    end
    case (cmd_i)
      CMD_DECODE: begin
        if (op_q == OP_SET && clk_zero) begin
          sat_q <= 1'b1;
        end
      end
      CMD_PREP: begin
        qwhole_q <= div_quot;
        num_q    <= frac_num;
      end
      CMD_ROUND: num_q <= MilliNumW'(div_quot[FracNumW-1:0]) + MilliNumW'(MilliHalf);
      CMD_SUM:   sat_q <= sum_sat;
      CMD_MUL:   prod_q <= (2*WordW)'(word_q) * (2*WordW)'(sysclk_q);
      CMD_FRAC:  scaled_hi_q <= low_scaled[42:32];
      CMD_PUBLISH: begin
        out_word_q  <= word_q;
        out_whole_q <= prod_q[2*WordW-1:WordW];
        out_milli_q <= ms_inc[10:1];
        out_sat_q   <= sat_q;
      end
      default: ;
    endcase
    // top bit of the dividend starts as the remainder of the first digit
    if (kd_start) begin
      kd_num_q  <= num_q[2*DigitW-1:0];
      kd_rem_q  <= MilliW'(num_q[MilliNumW-1]);
      kd_quot_q <= '0;
    end else if (kd_busy_q) begin
      if (!kd_phase_q) begin
        kd_digit_q <= kd_prod[RecipShift+DigitW-1:RecipShift];
      end else begin
        kd_num_q  <= {kd_num_q[DigitW-1:0], {DigitW{1'b0}}};
        kd_rem_q  <= kd_back[MilliW-1:0];
        kd_quot_q <= {kd_quot_q[DigitW-1:0], kd_digit_q};
      end
    end
  end

  assign status_o.op_set   = (op_q == OP_SET);
  assign status_o.clk_zero = clk_zero;
  assign status_o.div_done = div_done || kd_done_q;
  assign status_o.out_free = !out_valid_q || m_ready_i;

  assign sysclk_o    = sysclk_q;
  assign m_valid_o   = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_whole_o = out_whole_q;
  assign out_milli_o = out_milli_q;
  assign out_sat_o   = out_sat_q;

endmodule

>>> design/dtwc_ctrl.sv
// sequencer that steps the datapath through one request
module dtwc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  dtwc_pkg::dp_status_t status_i,
  output logic                 s_ready_o,
  output dtwc_pkg::cmd_e       cmd_o
);
  import dtwc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV1,
    ST_PREP,
    ST_DIV2,
    ST_ROUND,
    ST_DIV3,
    ST_SUM,
    ST_MUL,
    ST_FRAC,
    ST_DONE
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  logic   ready_q;

  // a command issued on entry to a state is carried out during that state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_NONE;
      ready_q <= 1'b1;
    end else begin
      cmd_q <= CMD_NONE;
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i && ready_q) begin
            ready_q <= 1'b0;
            state_q <= ST_DECODE;
            cmd_q   <= CMD_DECODE;
          end
        end
        ST_DECODE: begin
          if (status_i.op_set && !status_i.clk_zero) begin
            state_q <= ST_DIV1;
          end else begin
            state_q <= ST_MUL;
            cmd_q   <= CMD_MUL;
          end
        end
        ST_DIV1: begin
          if (status_i.div_done) begin
            state_q <= ST_PREP;
            cmd_q   <= CMD_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_DIV2;
          cmd_q   <= CMD_DIV2;
        end
        ST_DIV2: begin
          if (status_i.div_done) begin
            state_q <= ST_ROUND;
            cmd_q   <= CMD_ROUND;
          end
        end
        ST_ROUND: begin
          state_q <= ST_DIV3;
          cmd_q   <= CMD_DIV3;
        end
        ST_DIV3: begin
          if (status_i.div_done) begin
            state_q <= ST_SUM;
            cmd_q   <= CMD_SUM;
          end
        end
        ST_SUM: begin
          state_q <= ST_MUL;
          cmd_q   <= CMD_MUL;
        end
        ST_MUL: begin
          state_q <= ST_FRAC;
          cmd_q   <= CMD_FRAC;
        end
        ST_FRAC: state_q <= ST_DONE;
        ST_DONE: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
            cmd_q   <= CMD_PUBLISH;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign s_ready_o = ready_q;
  assign cmd_o     = cmd_q;

endmodule

>>> design/dds_tuning_word_converter_unit.sv
// top level of the dds frequency tuning word converter
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid / tready    tuser op, tdata whole hz + milli hz
//  m_axis    out  tvalid / tready    tuser saturated, tdata word + whole hz + milli hz
//  apb       in   psel / penable     sysclk_hz at byte address 0
//
// read, restore, the unused op and a set with a zero clock go from decode to multiply, fraction and publish
// a set with a nonzero clock makes two passes of the shared restoring divider at one
//   quotient bit per cycle (64 and 44 steps), a reciprocal divide by one thousand
//   and the prepare, round, sum, multiply and fraction steps
// one request at a time; the next is taken while a result still waits in the
//   output register, and a stalled result holds its place
// asynchronous active-low reset restores the default word and clock register
module dds_tuning_word_converter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [47:0]                s_axis_tdata_i,  // freq_whole_hz[31:0], freq_milli_hz[41:32]
  input  logic [1:0]                 s_axis_tuser_i,  // op[1:0]
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [79:0]                m_axis_tdata_o,  // tuning_word[31:0], out_whole_hz[63:32],
                                                      // out_milli_hz[73:64]
  output logic [0:0]                 m_axis_tuser_o,  // saturated[0]
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [dtwc_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output logic [31:0]                prdata_o,
  output logic                       pready_o
);
  import dtwc_pkg::*;

  logic             s_fire, cfg_we;
  cmd_e             cmd;
  dp_status_t       status;
  logic [WordW-1:0] sysclk, out_word, out_whole;
  logic [MilliW-1:0] out_milli;
  logic             out_sat;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && (paddr_i[2] == RegIdxSysclk);
  assign prdata_o = (paddr_i[2] == RegIdxSysclk) ? sysclk : '0;

  dtwc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .status_i  (status),
    .s_ready_o (s_axis_tready_o),
    .cmd_o     (cmd)
  );

  dtwc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capture_i   (s_fire),
    .op_i        (op_e'(s_axis_tuser_i)),
    .whole_i     (s_axis_tdata_i[31:0]),
    .milli_i     (s_axis_tdata_i[41:32]),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata_i),
    .cmd_i       (cmd),
    .m_ready_i   (m_axis_tready_i),
    .status_o    (status),
    .sysclk_o    (sysclk),
    .m_valid_o   (m_axis_tvalid_o),
    .out_word_o  (out_word),
    .out_whole_o (out_whole),
    .out_milli_o (out_milli),
    .out_sat_o   (out_sat)
  );

  assign m_axis_tdata_o = {6'b0, out_milli, out_whole, out_word};
  assign m_axis_tuser_o = out_sat;

endmodule

>>> design/dtwc_checker.sv
// port-level checks of the tuning word converter and their binding
`include "dds_tuning_word_converter_unit_macros.svh"

module dtwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // a held result keeps its payload
  `DTWC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // one request in flight: ready drops right after an accept
  `DTWC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "second request taken while busy")

  // a clamped set always reports the all-ones word
  `DTWC_ASSERT_NOW(a_sat_word, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o[31:0] == 32'hFFFF_FFFF, "saturated without full word")

  // rounded thousandths never pass one thousand
  `DTWC_ASSERT_NOW(a_milli_range, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[73:64] <= 10'd1000, "thousandths out of range")

endmodule

bind dds_tuning_word_converter_unit dtwc_checker u_dtwc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
